// ===== hdl/nrwt_pkg.sv =====
// Shared types, sizes and status codes for the nonce replay window table.
`default_nettype none

package nrwt_pkg;

    // Table geometry.
    localparam int ENTRIES = 256;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int NOW_W  = 63;
    localparam int WORD_W = 64;
    localparam int DIG_W  = 4 * WORD_W;
    localparam int WIN_W  = 32;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 32'd600;

    // Result codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_ACCEPT  = 2'd0;
    localparam t_status ST_REPLAY  = 2'd1;
    localparam t_status ST_FULL    = 2'd2;
    localparam t_status ST_BADTIME = 2'd3;

    // One table row: the time stamp and the stored digest.
    typedef struct packed {
        logic [NOW_W-1:0] stamp;
        logic [DIG_W-1:0] digest;
    } t_row;

    // Verdict of the slot check unit for one row.
    typedef struct packed {
        logic live;
        logic match;
    } t_slot_result;

endpackage

`default_nettype wire

// ===== hdl/nrwt_slot_check.sv =====
// Slot check unit: decides whether one stored row is live and holds the probed digest.
`default_nettype none

module nrwt_slot_check
    import nrwt_pkg::*;
(
    input  wire logic              i_stamp_vld,
    input  wire t_row              i_row,
    input  wire logic [NOW_W-1:0]  i_now,
    input  wire logic [DIG_W-1:0]  i_digest,
    input  wire logic [WIN_W-1:0]  i_window,
    output t_slot_result           o_res
);

    logic [NOW_W-1:0] age;
    logic             stamp_set;
    logic             in_future;

    // A slot never written reads as an empty stamp.
    assign stamp_set = i_stamp_vld && (i_row.stamp != '0);
    assign in_future = i_row.stamp > i_now;
    assign age       = i_now - i_row.stamp;

    assign o_res.live  = stamp_set &&
                         (in_future || (age <= {{(NOW_W - WIN_W){1'b0}}, i_window}));
    assign o_res.match = (i_row.digest == i_digest);

endmodule

`default_nettype wire

// ===== hdl/nonce_replay_window_table.sv =====
// Top level of the nonce replay window table: slot memory, scan sequencer and stream ports.
`default_nettype none

// Replay cache for 256-bit nonce digests. Each input transaction carries the
// current time in seconds and a digest; the block answers with one status
// transaction: accepted and stored, replay seen, table full, or invalid time.
// A slot is live when its stamp is nonzero and either lies in the future or
// is at most window_seconds old; a digest matching any live slot is a replay,
// otherwise it is stored in the lowest-numbered slot that is not live. The
// table holds ENTRIES rows in one memory with a single read port, and the
// sequencer walks that port one slot per cycle; a full walk ends in a write
// into the free slot or, with no slot free, in a full status. A replay ends
// the walk at the matching slot, and a zero time goes to the status hand-over
// without a walk. The input is not ready while an item is at work, but the
// next item may be accepted while the previous status still waits on the
// output. All slots are empty after reset, with no clearing pass; the window
// register resets to 600 and is to be written through i_cfg_we/i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.

module nonce_replay_window_table
    import nrwt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // Configuration: window_seconds.
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,

    // Request stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, from bit 0 up: now_seconds[62:0], digest_word0[63:0],
    // digest_word1[63:0], digest_word2[63:0], digest_word3[63:0], one pad bit.
    input  wire logic [319:0] s_axis_tdata,

    // Status stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, from bit 0 up: status[1:0], six pad bits.
    output logic [7:0]        m_axis_tdata
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_pend;
    logic [SLOT_W-1:0] r_pend_slot;
    logic              r_have_free, n_have_free;
    logic [SLOT_W-1:0] r_free, n_free;
    logic [NOW_W-1:0]  r_now, n_now;
    logic [DIG_W-1:0]  r_dig, n_dig;
    t_status           r_status, n_status;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [WIN_W-1:0]  r_window;

    // Slot storage: the stamps and digests live in one memory, and a valid
    // bit per slot stands for the all-zero stamp that reset gives.
    t_row              r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    t_row              r_row;
    logic              r_row_vld;

    logic              s_accept;
    logic              issue_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    t_slot_result      slot_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign issue_en      = (r_state == S_SCAN) && (r_issue < CNT_W'(ENTRIES));
    assign rd_addr       = r_issue[SLOT_W-1:0];
    assign mem_we        = (r_state == S_WRITE);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_status};

    // The one compare unit, fed by the registered memory read each cycle.
    nrwt_slot_check u_check (
        .i_stamp_vld (r_row_vld),
        .i_row       (r_row),
        .i_now       (r_now),
        .i_digest    (r_dig),
        .i_window    (r_window),
        .o_res       (slot_res)
    );

    // Sequencer. Reads are issued one slot per cycle and evaluated in the next
    // cycle, when the row has come out of the memory register.
    always_comb begin
        n_state      = r_state;
        n_issue      = r_issue;
        n_have_free  = r_have_free;
        n_free       = r_free;
        n_now        = r_now;
        n_dig        = r_dig;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_now       = s_axis_tdata[NOW_W-1:0];
                    n_dig       = s_axis_tdata[NOW_W +: DIG_W];
                    n_issue     = '0;
                    n_have_free = 1'b0;
                    if (s_axis_tdata[NOW_W-1:0] == '0) begin
                        n_status = ST_BADTIME;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issue_en) begin
                    n_issue = r_issue + CNT_W'(1);
                end
                if (r_pend) begin
                    if (slot_res.live && slot_res.match) begin
                        // First live match ends the walk.
                        n_status = ST_REPLAY;
                        n_state  = S_DONE;
                    end else begin
                        if (!slot_res.live && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free      = r_pend_slot;
                        end
                        if (r_pend_slot == SLOT_W'(ENTRIES - 1)) begin
                            if (n_have_free) begin
                                n_state = S_WRITE;
                            end else begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end
                        end
                    end
                end
            end
            S_WRITE: begin
                n_status = ST_ACCEPT;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // Hand the status over once the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= '0;
            r_pend      <= 1'b0;
            r_have_free <= 1'b0;
            r_out_valid <= 1'b0;
            r_window    <= WINDOW_RESET;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_pend      <= issue_en;
            r_have_free <= n_have_free;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (mem_we) begin
                r_valid[r_free] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend_slot  <= rd_addr;
        r_free       <= n_free;
        r_now        <= n_now;
        r_dig        <= n_dig;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_row_vld    <= r_valid[rd_addr];
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_free] <= t_row'{stamp: r_now, digest: r_dig};
        end
        r_row <= r_mem[rd_addr];
    end

    // A row is written only into a slot that the walk found free.
    a_write_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_have_free)
        else $error("slot write without a free slot");

    // A new status appears only out of the hand-over state.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_DONE))
        else $error("status raised outside the hand-over state");

    // The read pointer never runs past the end of the table.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue <= CNT_W'(ENTRIES))
        else $error("read pointer beyond the table");

endmodule

`default_nettype wire

// ===== bench/nonce_replay_window_table_checker.sv =====
// Checker for the nonce replay window table: predicts every status and compares it.
`timescale 1ns / 100ps

module nonce_replay_window_table_checker
    import nrwt_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [319:0] i_s_tdata,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [7:0]   i_m_tdata,
    output int                o_mismatches,
    output int                o_awaited
);

    // Private copy of the table and of the window register.
    logic [NOW_W-1:0] stamp_copy [ENTRIES];
    logic [DIG_W-1:0] digest_copy [ENTRIES];
    logic [WIN_W-1:0] window_copy;

    // Statuses predicted for accepted requests, oldest first.
    t_status status_due [$];

    task automatic note_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_mismatches++;
    endtask

    // Works out the status of one request and updates the table copy.
    function automatic t_status judge_request(input logic [NOW_W-1:0] now,
                                              input logic [DIG_W-1:0] dig);
        int  free_slot;
        logic live;
        free_slot = -1;
        if (now == '0) begin
            return ST_BADTIME;
        end
        for (int s = 0; s < ENTRIES; s++) begin
            live = (stamp_copy[s] != '0) &&
                   ((stamp_copy[s] > now) || ((now - stamp_copy[s]) <= window_copy));
            if (live) begin
                if (digest_copy[s] == dig) begin
                    return ST_REPLAY;
                end
            end else if (free_slot < 0) begin
                free_slot = s;
            end
        end
        if (free_slot < 0) begin
            return ST_FULL;
        end
        stamp_copy[free_slot]  = now;
        digest_copy[free_slot] = dig;
        return ST_ACCEPT;
    endfunction

    always @(posedge i_clk) begin
        t_status want;
        if (!i_rst_n) begin
            for (int s = 0; s < ENTRIES; s++) begin
                stamp_copy[s]  = '0;
                digest_copy[s] = '0;
            end
            window_copy = WINDOW_RESET;
            status_due.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                window_copy = i_cfg_wdata;
            end
            // A result can only belong to a request accepted at an earlier edge.
            if (i_m_tvalid && i_m_tready) begin
                if (status_due.size() == 0) begin
                    note_mismatch($sformatf("status %0d with no request waiting",
                                            i_m_tdata[1:0]));
                end else begin
                    want = status_due.pop_front();
                    if (i_m_tdata[1:0] !== want) begin
                        note_mismatch($sformatf("status %0d, predicted %0d",
                                                i_m_tdata[1:0], want));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                status_due.push_back(judge_request(i_s_tdata[62:0], i_s_tdata[318:63]));
            end
        end
        o_awaited = status_due.size();
    end

endmodule

// ===== bench/nonce_replay_window_table_test.sv =====
// Testbench top for the nonce replay window table: stimulus, reset and verdict.
`timescale 1ns / 100ps

module nonce_replay_window_table_test
    import nrwt_pkg::*;
;

    // Slowest legal run is roughly 1950 items, each a full table walk, plus long stalls.
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int POOL_SIZE   = 24;
    localparam logic [NOW_W-1:0] TIME_MAX = {NOW_W{1'b1}};

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_we      = 1'b0;
    logic [31:0]  i_cfg_wdata   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    int mismatches;
    int awaited;
    int cycles = 0;

    // When set, neither side idles.
    logic quiet = 1'b0;

    // Time base that advances slowly so that stored stamps age and expire.
    logic [NOW_W-1:0] base_time = 63'd1000;
    logic [DIG_W-1:0] digest_pool [POOL_SIZE];

    // Remaining cycles of the current status stall.
    int stall_left = 0;

    always #1 i_clk = ~i_clk;

    nonce_replay_window_table uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    nonce_replay_window_table_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .o_mismatches(mismatches),
        .o_awaited   (awaited)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Status side: single-cycle idles about a third of the time, and now and
    // then a stall long enough that the next request is taken while a status
    // waits.
    always @(negedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(1499) == 0) begin
            stall_left = $urandom_range(300, 1);
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < 32) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [DIG_W-1:0] random_digest();
        logic [DIG_W-1:0] d;
        for (int w = 0; w < DIG_W / 32; w++) begin
            d[w*32 +: 32] = $urandom;
        end
        return d;
    endfunction

    // Mostly pooled digests so that replays are common; the rest are fresh.
    function automatic logic [DIG_W-1:0] pick_digest();
        if ($urandom_range(99) < 55) begin
            return digest_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return random_digest();
    endfunction

    // Next request time: mostly the advancing base, sometimes a past time,
    // rarely zero or an arbitrary full-width value (usually far in the future).
    function automatic logic [NOW_W-1:0] pick_time(input int step_max);
        int               pick;
        logic [NOW_W-1:0] back;
        pick = $urandom_range(99);
        if (pick < 2) begin
            return '0;
        end else if (pick == 2) begin
            return NOW_W'({$urandom, $urandom});
        end else if (pick < 8) begin
            back = NOW_W'($urandom_range(1000));
            return (back >= base_time) ? 63'd1 : base_time - back;
        end
        base_time = base_time + NOW_W'($urandom_range(step_max));
        return base_time;
    endfunction

    // Presents one request transaction and returns at the edge that accepts it.
    task automatic send_request(input logic [NOW_W-1:0] now, input logic [DIG_W-1:0] dig);
        int gap;
        gap = 0;
        if (!quiet) begin
            if ($urandom_range(24) == 0) begin
                gap = $urandom_range(300, 1);
            end else if ($urandom_range(99) < 32) begin
                gap = $urandom_range(4, 1);
            end
        end
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        // The top bit is padding; it is randomized because the block must ignore it.
        s_axis_tdata  <= {1'($urandom_range(1)), dig, now};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Holds the request side off until every predicted status has come back.
    task automatic wait_settled();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (awaited != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Every request yields a status, so the block is idle once all have arrived.
    task automatic write_window(input logic [31:0] value);
        wait_settled();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= $urandom;
    endtask

    task automatic run_phase(input int count, input int step_max);
        for (int n = 0; n < count; n++) begin
            send_request(pick_time(step_max), pick_digest());
        end
    endtask

    initial begin
        logic [DIG_W-1:0] dig_a;
        for (int p = 0; p < POOL_SIZE; p++) begin
            digest_pool[p] = random_digest();
        end
        dig_a = digest_pool[0];

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, window at its reset value of 600 seconds.
        send_request('0, dig_a);                          // zero time
        send_request(63'd1, dig_a);                       // stored in slot 0
        send_request(63'd1, dig_a);                       // replay, same second
        send_request(63'd601, dig_a);                     // replay, exactly window old
        send_request(63'd602, dig_a);                     // slot expired, stored again
        send_request(63'd602, dig_a ^ {1'b1, 255'd0});    // differs in the last word only
        send_request(63'd602, dig_a ^ 256'd1);            // differs in the first word only
        send_request(TIME_MAX, {DIG_W{1'b1}});            // largest time, all-ones digest
        send_request(63'd5, {DIG_W{1'b1}});               // future stamp still live: replay
        send_request(63'd5, '0);                          // all-zero digest stored
        send_request(63'd5, '0);                          // and replayed
        send_request(63'd2000, '0);                       // zero digest expired, stored again
        send_request(TIME_MAX, '0);                       // zero digest long expired, stored
        send_request('0, {DIG_W{1'b1}});                  // zero time with a known digest

        // Window at reset value; pause for the pipeline to empty now and then.
        base_time = 63'd3000;
        for (int chunk = 0; chunk < 3; chunk++) begin
            run_phase(115, 4);
            wait_settled();
        end

        // Widest window: nothing expires, so the table fills and reports full.
        write_window(32'hFFFF_FFFF);
        run_phase(400, 3);

        // Zero window with no idling: only same-second or future stamps stay live.
        write_window(32'd0);
        quiet = 1'b1;
        run_phase(300, 1);
        quiet = 1'b0;

        write_window(32'd3);
        run_phase(400, 2);

        write_window($urandom_range(2000, 1));
        run_phase(490, 8);

        wait_settled();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== nonce_replay_window_table.f =====
hdl/nrwt_pkg.sv
hdl/nrwt_slot_check.sv
hdl/nonce_replay_window_table.sv
bench/nonce_replay_window_table_checker.sv
bench/nonce_replay_window_table_test.sv
